[rtl/sprite_blit_alpha_blend_core_macros.svh]
// Assertion macros shared by the sprite blit alpha blend core
`ifndef SPRITE_BLIT_ALPHA_BLEND_CORE_MACROS_SVH
`define SPRITE_BLIT_ALPHA_BLEND_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite blit core: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite blit core: next-cycle check failed");

`endif

[rtl/sba_pkg.sv]
// Shared types and constants for the sprite blit alpha blend core
`default_nettype none

package sba_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int ADDR_W     = 24;
  localparam int PIX_W      = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

  // register reset values
  localparam logic [COORD_W-1:0] PLACE_RST  = 12'd0;
  localparam logic [DIM_W-1:0]   SCREEN_RST = 13'd500;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [PIX_W-1:0]   src_pixel;
    logic [COORD_W-1:0] sprite_col;
    logic [COORD_W-1:0] sprite_row;
    logic [PIX_W-1:0]   dest_pixel;
  } in_item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] dest_address;
    logic [PIX_W-1:0]  blended_pixel;
  } out_item_t;

  // clip and address result passed from the address unit
  typedef struct packed {
    logic              in_screen;
    logic [ADDR_W-1:0] address;
  } addr_res_t;

endpackage

`default_nettype wire

[rtl/sba_addr.sv]
// Clipping and linear framebuffer address for one sprite pixel
`default_nettype none

module sba_addr #(
  parameter int MAX_SCREEN_DIM = 4096
) (
  input  logic [sba_pkg::COORD_W-1:0] sprite_col,
  input  logic [sba_pkg::COORD_W-1:0] sprite_row,
  input  logic [sba_pkg::COORD_W-1:0] place_x,
  input  logic [sba_pkg::COORD_W-1:0] place_y,
  input  logic [sba_pkg::DIM_W-1:0]   screen_width,
  input  logic [sba_pkg::DIM_W-1:0]   screen_height,
  output sba_pkg::addr_res_t          res
);
  import sba_pkg::*;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_SCREEN_DIM);

  logic [DIM_W-1:0]   col;
  logic [DIM_W-1:0]   row;
  logic [DIM_W-1:0]   w_sat;
  logic [DIM_W-1:0]   h_sat;
  logic [2*DIM_W-1:0] row_base;
  logic [2*DIM_W-1:0] lin;

  // target position on screen
  assign col = {1'b0, sprite_col} + {1'b0, place_x};
  assign row = {1'b0, sprite_row} + {1'b0, place_y};

  // screen size limited to the largest supported dimension
  assign w_sat = (screen_width  > DIM_MAX) ? DIM_MAX : screen_width;
  assign h_sat = (screen_height > DIM_MAX) ? DIM_MAX : screen_height;

  // row stride multiply and column offset
  assign row_base = row * w_sat;
  assign lin      = row_base + {{DIM_W{1'b0}}, col};

  assign res.in_screen = (col < w_sat) && (row < h_sat);
  assign res.address   = lin[ADDR_W-1:0];

endmodule

`default_nettype wire

[rtl/sba_blend.sv]
// BGRA to ARGB reorder and alpha blend over the framebuffer pixel
`default_nettype none

module sba_blend (
  input  logic [sba_pkg::PIX_W-1:0] src_bgra,
  input  logic [sba_pkg::PIX_W-1:0] cur_argb,
  output logic [sba_pkg::PIX_W-1:0] blended
);
  import sba_pkg::*;

  logic [PIX_W-1:0] src_argb;
  logic [7:0]       alpha;
  logic [7:0]       inv_alpha;
  logic [PIX_W-1:0] mixed;

  // byte reorder, alpha ends up in the top byte
  assign src_argb  = {src_bgra[7:0], src_bgra[15:8], src_bgra[23:16], src_bgra[31:24]};
  assign alpha     = src_argb[31:24];
  assign inv_alpha = ALPHA_OPAQUE - alpha;

  // per channel mix, floor of x/255 as (x + 1 + (x >> 8)) >> 8, exact for x up to 255*255
  always_comb begin
    logic [15:0] sum;
    logic [16:0] adj;
    mixed = {alpha, 24'd0};
    for (int c = 0; c < 3; c++) begin
      sum = ({8'd0, cur_argb[8*c +: 8]} * {8'd0, inv_alpha}) +
            ({8'd0, src_argb[8*c +: 8]} * {8'd0, alpha});
      adj = {1'b0, sum} + 17'd1 + {9'd0, sum[15:8]};
      mixed[8*c +: 8] = adj[15:8];
    end
  end

  // opaque source passes straight through
  assign blended = (alpha == ALPHA_OPAQUE) ? src_argb : mixed;

endmodule

`default_nettype wire

[rtl/sprite_blit_alpha_blend_core.sv]
// Top level of the sprite blit alpha blend core
// An item passes the input register, then the result register; address multiply and blends
// sit between them. One item per cycle unless out_stall holds the result register.
// in_stall rises only when both registers hold items and out_stall is high.
// Reset (rst_n low, synchronous) empties both registers, places the sprite at 0,0
// and sets the screen to 500 by 500.
`default_nettype none
`include "sprite_blit_alpha_blend_core_macros.svh"

module sprite_blit_alpha_blend_core #(
  parameter int MAX_SCREEN_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sba_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sba_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sba_pkg::*;

  logic [COORD_W-1:0] place_x_r;
  logic [COORD_W-1:0] place_y_r;
  logic [DIM_W-1:0]   screen_width_r;
  logic [DIM_W-1:0]   screen_height_r;

  logic      s1_vld_r;
  logic      s1_vld_nxt;
  in_item_t  s1_item_r;
  logic      s2_vld_r;
  logic      s2_vld_nxt;
  out_item_t s2_item_r;
  out_item_t s2_item_nxt;

  logic      s2_hold;
  logic      s1_adv;
  logic      s1_load;
  addr_res_t addr_res;
  logic [PIX_W-1:0] blend_pix;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_x_r       <= PLACE_RST;
      place_y_r       <= PLACE_RST;
      screen_width_r  <= SCREEN_RST;
      screen_height_r <= SCREEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLACE_X:       place_x_r       <= cfg_data[COORD_W-1:0];
        CFG_PLACE_Y:       place_y_r       <= cfg_data[COORD_W-1:0];
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // two-stage flow control
  assign s2_hold    = s2_vld_r & out_stall;
  assign s1_adv     = s1_vld_r & ~s2_hold;
  assign in_stall   = s1_vld_r & s2_hold;
  assign s1_load    = in_valid & ~in_stall;
  assign s1_vld_nxt = s1_load | (s1_vld_r & ~s1_adv);
  assign s2_vld_nxt = s1_adv | s2_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= in_item;
    end
  end

  // compute pass
  sba_addr #(
    .MAX_SCREEN_DIM(MAX_SCREEN_DIM)
  ) u_addr (
    .sprite_col   (s1_item_r.sprite_col),
    .sprite_row   (s1_item_r.sprite_row),
    .place_x      (place_x_r),
    .place_y      (place_y_r),
    .screen_width (screen_width_r),
    .screen_height(screen_height_r),
    .res          (addr_res)
  );

  sba_blend u_blend (
    .src_bgra(s1_item_r.src_pixel),
    .cur_argb(s1_item_r.dest_pixel),
    .blended (blend_pix)
  );

  // clipped pixels give an all-zero item
  always_comb begin
    s2_item_nxt.write_enable  = addr_res.in_screen;
    s2_item_nxt.dest_address  = addr_res.in_screen ? addr_res.address : '0;
    s2_item_nxt.blended_pixel = addr_res.in_screen ? blend_pix : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_item  = s2_item_r;

  // checks
  `SBA_ASSERT_SAME(a_clip_zero, clk, rst_n,
    out_valid && !out_item.write_enable,
    out_item.dest_address == '0 && out_item.blended_pixel == '0)
  `SBA_ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_vld_r && !s2_hold, s2_vld_r)
  `SBA_ASSERT_SAME(a_stall_full, clk, rst_n, in_stall, s1_vld_r && s2_vld_r && out_stall)

endmodule

`default_nettype wire
